### rtl/pcfp_pkg.sv
// Shared types and constants for the PWM channel frame packer.
`timescale 1ns / 1ps

package pcfp_pkg;

    localparam int CHANNELS_PER_DEVICE = 24;
    localparam int CHANNEL_W           = 6;
    localparam int VALUE_W             = 16;
    localparam int PWM_W               = 12;
    localparam int WORD_W              = 2 * PWM_W;

    // Request codes, as carried on func
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    // Classified request handed from the front queue to the back end
    typedef struct packed {
        op_t                  op;
        logic                 bad;
        logic [CHANNEL_W-1:0] channel;
        logic [VALUE_W-1:0]   value;
    } cmd_t;

endpackage

### rtl/pwm_channel_frame_packer.sv
// Top level of the PWM channel frame packer.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-----------------------------------------------
//  request  | in_valid  | in_stall  | func, channel, value
//  result   | out_valid | out_stall | status, read_value, frame_word, is_frame, last
//
// Write, read and clear each make a single store access in the back end; a
// request passes the queue, the read data stage and the result register.
// A flush first takes an issue slot for setup, then DEVICES*12 frame words at one
// per cycle unless stalled, paced by the single issue slot ahead of both read ports.
// Reset clears every written flag at once, so the store reads zero right away.
// A two-entry queue decouples the sides; in_stall rises only when it is full.
`timescale 1ns / 1ps

module pwm_channel_frame_packer
    import pcfp_pkg::*;
#(
    parameter int DEVICES = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           func,
    input  logic [CHANNEL_W-1:0] channel,
    input  logic [VALUE_W-1:0]   value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 status,
    output logic [VALUE_W-1:0]   read_value,
    output logic [WORD_W-1:0]    frame_word,
    output logic                 is_frame,
    output logic                 last
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    pcfp_front #(
        .DEVICES (DEVICES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .channel   (channel),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    pcfp_back #(
        .DEVICES (DEVICES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_value (read_value),
        .frame_word (frame_word),
        .is_frame   (is_frame),
        .last       (last)
    );

endmodule

### rtl/pcfp_front.sv
// Front end: accepts requests, checks the channel range, queues them.
`timescale 1ns / 1ps

module pcfp_front
    import pcfp_pkg::*;
#(
    parameter int DEVICES = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           func,
    input  logic [CHANNEL_W-1:0] channel,
    input  logic [VALUE_W-1:0]   value,
    output logic                 cmd_valid,
    output cmd_t                 cmd,
    input  logic                 cmd_pop
);

    localparam int TOTAL = DEVICES * CHANNELS_PER_DEVICE;

    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    cmd_t       q_reg [2];
    cmd_t       cls;
    logic       push;
    logic       pop;

    // Classify the incoming request
    always_comb
    begin
        cls.op      = op_t'(func);
        cls.bad     = ({2'b00, channel} >= 8'(TOTAL));
        cls.channel = channel;
        cls.value   = value;
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    // Queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Queue entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### rtl/pcfp_back.sv
// Back end: channel store, flush sequencer and result register.
`timescale 1ns / 1ps

module pcfp_back
    import pcfp_pkg::*;
#(
    parameter int DEVICES = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [VALUE_W-1:0] read_value,
    output logic [WORD_W-1:0]  frame_word,
    output logic               is_frame,
    output logic               last
);

    localparam int TOTAL = DEVICES * CHANNELS_PER_DEVICE;
    localparam int AW    = $clog2(TOTAL);

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [AW-1:0]      flush_hi_reg;
    logic [AW-1:0]      flush_hi_next;

    // channel store: contents plus a written flag per entry
    logic [VALUE_W-1:0] mem [TOTAL];
    logic [TOTAL-1:0]   vld_reg;
    logic [VALUE_W-1:0] rd_a_reg;
    logic [VALUE_W-1:0] rd_b_reg;
    logic               rdv_a_reg;
    logic               rdv_b_reg;

    // issue stage outputs
    logic               issue_en;
    logic               out_adv;
    logic               iss_valid;
    op_t                iss_op;
    logic               iss_status;
    logic               iss_last;
    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    logic [AW-1:0]      wr_addr;
    logic               mem_we;
    logic               vld_clear;

    // read data stage
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic               s1_status_reg;
    logic               s1_last_reg;

    // result register
    logic               out_valid_reg;
    logic               status_reg;
    logic [VALUE_W-1:0] read_value_reg;
    logic [WORD_W-1:0]  frame_word_reg;
    logic               is_frame_reg;
    logic               last_reg;

    logic [PWM_W-1:0]   pwm_a;
    logic [PWM_W-1:0]   pwm_b;

    assign out_adv  = !out_valid_reg || !out_stall;
    assign issue_en = !s1_valid_reg || out_adv;
    assign wr_addr  = AW'(cmd.channel);
    assign addr_b   = flush_hi_reg - AW'(1);

    // Issue: pick the next store access, one per cycle while issue_en holds
    always_comb
    begin
        cmd_pop       = 1'b0;
        iss_valid     = 1'b0;
        iss_op        = cmd.op;
        iss_status    = 1'b0;
        iss_last      = 1'b1;
        addr_a        = AW'(cmd.channel);
        mem_we        = 1'b0;
        vld_clear     = 1'b0;
        state_next    = state_reg;
        flush_hi_next = flush_hi_reg;
        if (issue_en)
        begin
            unique case (state_reg)
                ST_FLUSH:
                begin
                    iss_valid     = 1'b1;
                    iss_op        = OP_FLUSH;
                    addr_a        = flush_hi_reg;
                    iss_last      = (flush_hi_reg == AW'(1));
                    flush_hi_next = flush_hi_reg - AW'(2);
                    if (iss_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_pop = 1'b1;
                        unique case (cmd.op)
                            OP_WRITE:
                            begin
                                iss_valid  = 1'b1;
                                iss_status = cmd.bad;
                                mem_we     = !cmd.bad;
                            end
                            OP_READ:
                            begin
                                iss_valid  = 1'b1;
                                iss_status = cmd.bad;
                            end
                            OP_CLEAR:
                            begin
                                iss_valid = 1'b1;
                                vld_clear = 1'b1;
                            end
                            OP_FLUSH:
                            begin
                                state_next    = ST_FLUSH;
                                flush_hi_next = AW'(TOTAL - 1);
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // Store contents and registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= cmd.value;
        end
        if (issue_en)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    // Top 12 bits of each value; an unwritten entry reads as zero
    assign pwm_a = rdv_a_reg ? rd_a_reg[VALUE_W-1 -: PWM_W] : '0;
    assign pwm_b = rdv_b_reg ? rd_b_reg[VALUE_W-1 -: PWM_W] : '0;

    // Sequencer state, pipeline control and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            flush_hi_reg   <= '0;
            vld_reg        <= '0;
            rdv_a_reg      <= 1'b0;
            rdv_b_reg      <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_op_reg      <= OP_WRITE;
            s1_status_reg  <= 1'b0;
            s1_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            status_reg     <= 1'b0;
            read_value_reg <= '0;
            frame_word_reg <= '0;
            is_frame_reg   <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            flush_hi_reg <= flush_hi_next;
            if (vld_clear)
            begin
                vld_reg <= '0;
            end
            else if (mem_we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (issue_en)
            begin
                rdv_a_reg     <= vld_reg[addr_a];
                rdv_b_reg     <= vld_reg[addr_b];
                s1_valid_reg  <= iss_valid;
                s1_op_reg     <= iss_op;
                s1_status_reg <= iss_status;
                s1_last_reg   <= iss_last;
            end
            if (out_adv)
            begin
                out_valid_reg  <= s1_valid_reg;
                status_reg     <= s1_status_reg;
                read_value_reg <= (s1_op_reg == OP_READ && !s1_status_reg && rdv_a_reg)
                                  ? rd_a_reg : '0;
                frame_word_reg <= (s1_op_reg == OP_FLUSH) ? {pwm_a, pwm_b} : '0;
                is_frame_reg   <= (s1_op_reg == OP_FLUSH);
                last_reg       <= s1_last_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign frame_word = frame_word_reg;
    assign is_frame   = is_frame_reg;
    assign last       = last_reg;

endmodule

### rtl/pcfp_checker.sv
// Port-level checks for the PWM channel frame packer, bound to the top level.
`timescale 1ns / 1ps

module pcfp_checker
    import pcfp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic [1:0]           func,
    input logic [CHANNEL_W-1:0] channel,
    input logic [VALUE_W-1:0]   value,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 status,
    input logic [VALUE_W-1:0]   read_value,
    input logic [WORD_W-1:0]    frame_word,
    input logic                 is_frame,
    input logic                 last
);

    // A stalled request keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(func)
            && $stable(channel) && $stable(value))
        else $error("request changed while stalled");

    // A held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_word)
            && $stable(read_value) && $stable(status) && $stable(last))
        else $error("result changed while stalled");

    // Frame words never carry an error or read data
    a_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_frame |-> !status && read_value == '0)
        else $error("frame word with status or read data");

    // Single results always close their request
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_frame |-> last && frame_word == '0)
        else $error("non-frame result not marked last");

    // An invalid channel returns no data
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> read_value == '0 && !is_frame)
        else $error("invalid channel returned data");

endmodule

bind pwm_channel_frame_packer pcfp_checker u_pcfp_checker (.*);
